@@ hdl/ebusmt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebusmt_pkg
// Shared types, constants and the CRC-8 step for the eBUS master core.
// ----------------------------------------------------------------------------
package ebusmt_pkg;

  localparam int MaxTelegramDef = 32;   // default telegram store capacity
  localparam int ResDepth       = 4;    // result queue entries

  localparam logic [7:0] CrcPoly = 8'h9B;
  localparam logic [7:0] SynByte = 8'hAA;
  localparam logic [7:0] AckByte = 8'h00;
  localparam logic [7:0] NakByte = 8'hFF;
  localparam logic [7:0] TopBit  = 8'h80;

  // telegram_type codes
  localparam logic [1:0] TypeMasterMaster = 2'd1;
  localparam logic [1:0] TypeMasterSlave  = 2'd2;
  localparam logic [1:0] TypeBroadcast    = 2'd3;

  // input action codes
  localparam logic ActLoad    = 1'b0;
  localparam logic ActReceive = 1'b1;

  // result kinds
  localparam logic KindTx     = 1'b0;
  localparam logic KindStatus = 1'b1;

  // status codes
  localparam logic [7:0] StOk       = 8'd0;
  localparam logic [7:0] StCrcBad   = 8'd1;
  localparam logic [7:0] StSlaveNak = 8'd2;
  localparam logic [7:0] StEchoErr  = 8'd3;
  localparam logic [7:0] StOverflow = 8'd4;

  typedef enum logic [2:0] {
    PH_LOADING   = 3'b001,
    PH_RECEIVING = 3'b010,
    PH_DONE      = 3'b100
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } res_t;

  // eBUS bit-serial CRC-8: shift data in MSB first, xor poly on carry out
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       top;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      top = (c & TopBit) != 8'h00;
      c   = {c[6:0], d[7]};
      if (top) begin
        c = c ^ CrcPoly;
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ hdl/ebus_master_transaction_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebus_master_transaction_core
// eBUS master telegram engine: load, transmit with CRC, echo check, answer.
// ----------------------------------------------------------------------------
// Usage: each input item is either a telegram byte to load (tuser = 0, tlast
// marks the final byte) or a byte seen on the bus (tuser = 1). Loaded bytes
// come straight back as transmit items; the final one is followed by the
// CRC-8 (poly 0x9B) and, for broadcast, by SYN. Bus bytes are checked against
// the stored echo, then the slave answer is collected and the core replies
// ACK/NAK (not for master-master) and SYN and posts a status item (tuser = 1).
// Each input item yields zero to three result items, which go into a four-entry
// result queue that drains one item per cycle while the output is ready. The
// input is ready whenever the queue has room for three results, so items flow
// back to back as long as the output keeps pace. telegram_type is to be written
// on the cfg channel only while the core is idle; the core does not enforce this.
module ebus_master_transaction_core #(
  parameter int MAX_TELEGRAM = ebusmt_pkg::MaxTelegramDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: telegram_type
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  // input items
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] action
  input  logic       s_axis_tlast,   // end_of_message
  // result items
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] value
  output logic       m_axis_tuser,   // [0] kind
  output logic       m_axis_tlast    // last result of its input item
);
  import ebusmt_pkg::*;

  localparam int CntW = $clog2(MAX_TELEGRAM + 1);  // holds 0..MAX_TELEGRAM
  localparam int IdxW = $clog2(MAX_TELEGRAM);      // store address
  localparam int PtrW = $clog2(ResDepth);
  localparam int QcW  = $clog2(ResDepth + 1);

  // ---------------------------------------------------------------- state
  logic [1:0]      type_q;
  phase_e          phase_q, phase_d;
  logic [CntW-1:0] sent_q, sent_d;
  logic [CntW-1:0] echo_q, echo_d;
  logic [8:0]      ans_cnt_q, ans_cnt_d;
  logic [7:0]      ans_first_q, ans_first_d;
  logic [7:0]      ans_len_q, ans_len_d;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      crc_sent_q, crc_sent_d;   // CRC byte of the telegram

  // telegram store (data bytes only; CRC is held in crc_sent_q)
  logic [7:0]      sent_mem [MAX_TELEGRAM];
  logic [7:0]      rd_q;                      // prefetched mem[echo index]
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [IdxW-1:0] mem_raddr;

  // result queue
  res_t            resq_q [ResDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QcW-1:0]  qcnt_q;

  // per-item results
  res_t            res [3];
  logic [1:0]      res_n;

  // ---------------------------------------------------------------- handshake
  logic in_acc, out_acc;
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = qcnt_q <= QcW'(ResDepth - 3);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = qcnt_q != '0;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = resq_q[rd_ptr_q].value;
  assign m_axis_tuser  = resq_q[rd_ptr_q].kind;
  assign m_axis_tlast  = resq_q[rd_ptr_q].last;

  // ---------------------------------------------------------------- item logic
  logic            restart;
  logic [CntW-1:0] cnt_eff;
  logic [7:0]      crc_eff, crc_new, expected, first_eff;
  logic            in_echo, bad_crc;
  logic [8:0]      ans_end;

  always_comb begin
    phase_d     = phase_q;
    sent_d      = sent_q;
    echo_d      = echo_q;
    ans_cnt_d   = ans_cnt_q;
    ans_first_d = ans_first_q;
    ans_len_d   = ans_len_q;
    crc_d       = crc_q;
    crc_sent_d  = crc_sent_q;
    res_n       = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
    end
    mem_we    = 1'b0;
    restart   = phase_q != PH_LOADING;
    cnt_eff   = restart ? '0 : sent_q;
    crc_eff   = restart ? 8'h00 : crc_q;
    crc_new   = crc_step(crc_eff, s_axis_tdata);
    mem_waddr = cnt_eff[IdxW-1:0];
    in_echo   = echo_q < sent_q;
    // last echo position is the CRC byte
    expected  = (echo_q == sent_q - CntW'(1)) ? crc_sent_q : rd_q;
    first_eff = (ans_cnt_q == 9'd0) ? s_axis_tdata : ans_first_q;
    ans_end   = {1'b0, ans_len_q} + 9'd2;
    bad_crc   = (ans_first_q == AckByte) && (s_axis_tdata != crc_q);

    if (in_acc && s_axis_tuser == ActLoad) begin
      if (restart) begin
        // drop whatever transaction was running
        phase_d     = PH_LOADING;
        echo_d      = '0;
        ans_cnt_d   = '0;
        ans_first_d = '0;
        ans_len_d   = '0;
      end
      if ({1'b0, cnt_eff} + (CntW + 1)'(2) > (CntW + 1)'(MAX_TELEGRAM)) begin
        res[0]      = '{kind: KindStatus, value: StOverflow, last: 1'b0};
        res_n       = 2'd1;
        phase_d     = PH_LOADING;
        sent_d      = '0;
        echo_d      = '0;
        ans_cnt_d   = '0;
        ans_first_d = '0;
        ans_len_d   = '0;
        crc_d       = '0;
      end else begin
        mem_we = 1'b1;
        sent_d = cnt_eff + CntW'(1);
        crc_d  = crc_new;
        res[0] = '{kind: KindTx, value: s_axis_tdata, last: 1'b0};
        res_n  = 2'd1;
        if (s_axis_tlast) begin
          crc_sent_d = crc_new;
          sent_d     = cnt_eff + CntW'(2);
          res[1]     = '{kind: KindTx, value: crc_new, last: 1'b0};
          res_n      = 2'd2;
          if (type_q == TypeBroadcast) begin
            res[2]  = '{kind: KindTx, value: SynByte, last: 1'b0};
            res_n   = 2'd3;
            phase_d = PH_DONE;
          end else begin
            phase_d   = PH_RECEIVING;
            echo_d    = '0;
            ans_cnt_d = '0;
            crc_d     = '0;
          end
        end
      end
    end else if (in_acc && phase_q == PH_RECEIVING) begin
      if (s_axis_tdata == SynByte || (in_echo && s_axis_tdata != expected)) begin
        res[0]  = '{kind: KindStatus, value: StEchoErr, last: 1'b0};
        res_n   = 2'd1;
        phase_d = PH_DONE;
      end else if (in_echo) begin
        echo_d = echo_q + CntW'(1);
      end else begin
        if (ans_cnt_q == 9'd0) begin
          ans_first_d = s_axis_tdata;
        end
        if (ans_cnt_q == 9'd1) begin
          ans_len_d = s_axis_tdata;
        end
        if (type_q <= TypeMasterMaster) begin
          // master-master (type 0 too): one answer byte closes the exchange
          res[0]  = '{kind: KindTx, value: SynByte, last: 1'b0};
          res[1]  = '{kind: KindStatus,
                      value: (first_eff == NakByte) ? StSlaveNak : StOk, last: 1'b0};
          res_n   = 2'd2;
          phase_d = PH_DONE;
        end else if (ans_cnt_q == 9'd0 && s_axis_tdata == NakByte) begin
          res[0]  = '{kind: KindTx, value: AckByte, last: 1'b0};
          res[1]  = '{kind: KindTx, value: SynByte, last: 1'b0};
          res[2]  = '{kind: KindStatus, value: StSlaveNak, last: 1'b0};
          res_n   = 2'd3;
          phase_d = PH_DONE;
        end else if (ans_cnt_q >= 9'd2 && ans_cnt_q == ans_end) begin
          // answer CRC byte
          res[0]  = '{kind: KindTx, value: bad_crc ? NakByte : AckByte, last: 1'b0};
          res[1]  = '{kind: KindTx, value: SynByte, last: 1'b0};
          res[2]  = '{kind: KindStatus, value: bad_crc ? StCrcBad : StOk, last: 1'b0};
          res_n   = 2'd3;
          phase_d = PH_DONE;
        end else begin
          if (ans_cnt_q != 9'd0) begin
            crc_d = crc_step(crc_q, s_axis_tdata);
          end
          ans_cnt_d = ans_cnt_q + 9'd1;
        end
      end
    end

    for (int k = 0; k < 3; k++) begin
      res[k].last = (2'(k) == res_n - 2'd1);
    end
  end

  assign mem_raddr = echo_d[IdxW-1:0];

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q      <= TypeMasterSlave;
      phase_q     <= PH_LOADING;
      sent_q      <= '0;
      echo_q      <= '0;
      ans_cnt_q   <= '0;
      ans_first_q <= '0;
      ans_len_q   <= '0;
      crc_q       <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      qcnt_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        type_q <= cfg_data_i;
      end
      phase_q     <= phase_d;
      sent_q      <= sent_d;
      echo_q      <= echo_d;
      ans_cnt_q   <= ans_cnt_d;
      ans_first_q <= ans_first_d;
      ans_len_q   <= ans_len_d;
      crc_q       <= crc_d;
      wr_ptr_q    <= wr_ptr_q + PtrW'(res_n);
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      qcnt_q <= qcnt_q + QcW'(res_n) - QcW'(out_acc);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    crc_sent_q <= crc_sent_d;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < res_n) begin
        resq_q[wr_ptr_q + PtrW'(k)] <= res[k];
      end
    end
  end

  // telegram store, write-first read of the next echo position
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sent_mem[mem_waddr] <= s_axis_tdata;
    end
    if (mem_we && mem_waddr == mem_raddr) begin
      rd_q <= s_axis_tdata;
    end else begin
      rd_q <= sent_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------- checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= QcW'(ResDepth))
    else $error("result queue count beyond depth");

  a_recv_has_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RECEIVING |-> sent_q >= CntW'(2))
    else $error("receiving without a stored telegram and CRC");

  a_echo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    echo_q <= sent_q && sent_q <= CntW'(MAX_TELEGRAM))
    else $error("echo index or sent count out of range");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LOADING |-> echo_q == '0 && ans_cnt_q == '0)
    else $error("loading with stale echo or answer state");

  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> qcnt_q <= QcW'(ResDepth))
    else $error("accepted item overfilled result queue");

endmodule

@@ test/ebus_master_transaction_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebus_master_transaction_core_tb
// Self-checking bench for the eBUS master telegram core. A behavioral copy of
// the telegram engine predicts the transmit and status items for each
// accepted input item. Directed cases come first, then well-formed telegram
// exchanges with random content and faults, mixed with noise, under several
// idling patterns and all telegram_type settings.
// ----------------------------------------------------------------------------
module ebus_master_transaction_core_tb;
  import ebusmt_pkg::*;

  localparam int         TelegramCap   = MaxTelegramDef;
  localparam int         SettleCycles  = 8;
  localparam int         CycleLimit    = 300000;
  localparam int         PrintLimit    = 50;
  localparam logic [1:0] TypeZero      = 2'd0;   // behaves as master-master

  typedef enum int {
    ANS_GOOD,
    ANS_BAD_CRC,
    ANS_NAK,
    ANS_OTHER,
    ANS_ECHO_BAD,
    ANS_SYN
  } answer_mode_e;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i    = 2'd0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic       s_axis_tuser  = 1'b0;    // [0] action
  logic       s_axis_tlast  = 1'b0;    // end_of_message
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] value
  logic       m_axis_tuser;            // [0] kind
  logic       m_axis_tlast;            // last result of its input item

  ebus_master_transaction_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // telegram engine copy
  logic [1:0] eng_type = TypeMasterSlave;
  logic [7:0] eng_store [TelegramCap];
  int         eng_sent_n    = 0;
  int         eng_echo_pos  = 0;
  int         eng_ans_n     = 0;
  logic [7:0] eng_ans_first = 8'h00;
  logic [7:0] eng_ans_len   = 8'h00;
  logic [7:0] eng_crc       = 8'h00;
  phase_e     eng_phase     = PH_LOADING;

  res_t step_out [3];
  int   step_n;
  res_t expected_bus_out [$];

  int err_count       = 0;
  int items_sent      = 0;
  int cycle_count     = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[ebus_master_transaction_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PrintLimit) $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bus_out.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0d value %02h",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        want = expected_bus_out.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata !== want.value)
          report_mismatch($sformatf("value %02h, want %02h", m_axis_tdata, want.value));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", m_axis_tlast, want.last));
      end
    end
  end

  // eBUS CRC-8: bits enter MSB first, poly folded in on carry out
  function automatic logic [7:0] crc8_shift(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    logic       carry;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      carry = c[7];
      c = {c[6:0], b[i]} ^ (carry ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_payload_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    // mostly keep SYN out of payload so exchanges get past the echo
    if (b == SynByte && $urandom_range(3) != 0) b = ~b;
    return b;
  endfunction

  task automatic emit(input logic kind, input logic [7:0] value);
    step_out[step_n] = '{kind: kind, value: value, last: 1'b0};
    step_n++;
  endtask

  task automatic restart_telegram();
    eng_sent_n    = 0;
    eng_echo_pos  = 0;
    eng_ans_n     = 0;
    eng_ans_first = 8'h00;
    eng_ans_len   = 8'h00;
    eng_crc       = 8'h00;
    eng_phase     = PH_LOADING;
  endtask

  task automatic telegram_engine_step(input logic act, input logic [7:0] b, input logic eom);
    int   idx;
    logic bad;
    step_n = 0;
    if (act == ActLoad) begin
      if (eng_phase != PH_LOADING) restart_telegram();
      if (eng_sent_n + 2 > TelegramCap) begin
        emit(KindStatus, StOverflow);
        restart_telegram();
      end else begin
        eng_store[eng_sent_n] = b;
        eng_sent_n++;
        eng_crc = crc8_shift(eng_crc, b);
        emit(KindTx, b);
        if (eom) begin
          eng_store[eng_sent_n] = eng_crc;
          eng_sent_n++;
          emit(KindTx, eng_crc);
          if (eng_type == TypeBroadcast) begin
            emit(KindTx, SynByte);
            eng_phase = PH_DONE;
          end else begin
            eng_phase    = PH_RECEIVING;
            eng_echo_pos = 0;
            eng_ans_n    = 0;
            eng_crc      = 8'h00;
          end
        end
      end
    end else if (eng_phase == PH_RECEIVING) begin
      if (b == SynByte || (eng_echo_pos < eng_sent_n && b != eng_store[eng_echo_pos])) begin
        emit(KindStatus, StEchoErr);
        eng_phase = PH_DONE;
      end else if (eng_echo_pos < eng_sent_n) begin
        eng_echo_pos++;
      end else begin
        idx = eng_ans_n;
        if (idx == 0) eng_ans_first = b;
        if (idx == 1) eng_ans_len = b;
        if (eng_type <= TypeMasterMaster) begin
          // one answer byte closes a master-master exchange
          emit(KindTx, SynByte);
          emit(KindStatus, (eng_ans_first == NakByte) ? StSlaveNak : StOk);
          eng_phase = PH_DONE;
        end else if (idx == 0 && b == NakByte) begin
          emit(KindTx, AckByte);
          emit(KindTx, SynByte);
          emit(KindStatus, StSlaveNak);
          eng_phase = PH_DONE;
        end else if (idx >= 2 && idx == 2 + int'(eng_ans_len)) begin
          // CRC only judged when the slave opened with ACK
          bad = (eng_ans_first == AckByte) && (b != eng_crc);
          emit(KindTx, bad ? NakByte : AckByte);
          emit(KindTx, SynByte);
          emit(KindStatus, bad ? StCrcBad : StOk);
          eng_phase = PH_DONE;
        end else begin
          if (idx >= 1) eng_crc = crc8_shift(eng_crc, b);
          eng_ans_n = (idx + 1) & 'h1FF;
        end
      end
    end
    if (step_n > 0) step_out[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_bus_out.push_back(step_out[i]);
  endtask

  // Called in the time step of the previous acceptance (or after a wait), so
  // valid is only ever assigned once per step.
  task automatic send_item(input logic act, input logic [7:0] b, input logic eom);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= act;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    telegram_engine_step(act, b, eom);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_bus_out.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_telegram_type(input logic [1:0] ty);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ty;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    eng_type = ty;
  endtask

  // Echo the stored telegram back, then play the slave answer.
  task automatic answer_phase(input answer_mode_e mode, input int len);
    int         bad_pos;
    logic [7:0] b;
    logic [7:0] flip;
    logic [7:0] ans_crc;
    if (eng_phase != PH_RECEIVING) return;
    bad_pos = $urandom_range(eng_sent_n - 1);
    for (int i = 0; i < eng_sent_n && eng_phase == PH_RECEIVING; i++) begin
      b = eng_store[i];
      if (i == bad_pos && mode == ANS_ECHO_BAD) begin
        flip = 8'($urandom_range(1, 255));
        b = b ^ flip;
      end
      if (i == bad_pos && mode == ANS_SYN) b = SynByte;
      send_item(ActReceive, b, 1'($urandom_range(1)));
    end
    if (eng_phase != PH_RECEIVING) return;
    case (mode)
      ANS_NAK: b = NakByte;
      ANS_OTHER: begin
        b = 8'($urandom_range(1, 254));
        if (b == SynByte) b = 8'h55;
      end
      default: b = AckByte;
    endcase
    send_item(ActReceive, b, 1'b0);
    if (eng_phase != PH_RECEIVING) return;
    b = len[7:0];
    send_item(ActReceive, b, 1'b0);
    ans_crc = crc8_shift(8'h00, b);
    for (int i = 0; i < len && eng_phase == PH_RECEIVING; i++) begin
      b = pick_payload_byte();
      send_item(ActReceive, b, 1'($urandom_range(1)));
      ans_crc = crc8_shift(ans_crc, b);
    end
    if (eng_phase != PH_RECEIVING) return;
    b = ans_crc;
    if (mode == ANS_BAD_CRC || mode == ANS_OTHER) begin
      flip = 8'($urandom_range(1, 255));
      b = b ^ flip;
    end
    send_item(ActReceive, b, 1'b0);
  endtask

  task automatic play_transaction(input int n, input answer_mode_e mode, input int len);
    for (int i = 0; i < n; i++) send_item(ActLoad, pick_payload_byte(), i == n - 1);
    answer_phase(mode, len);
  endtask

  task automatic test_directed();
    send_item(ActReceive, 8'h55, 1'b1);     // bus byte while loading: ignored
    send_item(ActLoad, 8'h00, 1'b0);
    send_item(ActLoad, 8'hFF, 1'b1);
    answer_phase(ANS_GOOD, 1);
    send_item(ActReceive, 8'h00, 1'b0);     // bus byte once done: ignored
    play_transaction(1, ANS_NAK, 0);
    play_transaction(1, ANS_ECHO_BAD, 0);
    // new load while the echo is still running restarts the telegram
    send_item(ActLoad, 8'h3C, 1'b1);
    send_item(ActReceive, eng_store[0], 1'b0);
    send_item(ActLoad, 8'hC3, 1'b1);
    answer_phase(ANS_BAD_CRC, 0);
  endtask

  task automatic test_telegram_types();
    write_telegram_type(TypeMasterMaster);
    play_transaction(2, ANS_GOOD, 0);
    play_transaction(1, ANS_NAK, 0);
    write_telegram_type(TypeZero);
    play_transaction(1, ANS_OTHER, 0);
    write_telegram_type(TypeBroadcast);
    play_transaction(3, ANS_GOOD, 0);
    send_item(ActReceive, SynByte, 1'b0);
    write_telegram_type(TypeMasterSlave);
    play_transaction(2, ANS_OTHER, 1);
    play_transaction(1, ANS_SYN, 0);
  endtask

  task automatic test_overflow();
    // the last of these finds no room for itself plus the CRC
    for (int i = 0; i < TelegramCap; i++)
      send_item(ActLoad, 8'($urandom_range(255)), 1'b0);
    play_transaction(TelegramCap - 1, ANS_GOOD, 2);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [1:0] ty, input int budget);
    int           first_item;
    int           n;
    int           len;
    answer_mode_e mode;
    write_telegram_type(ty);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    first_item = items_sent;
    while (items_sent - first_item < budget) begin
      if ($urandom_range(99) < 80) begin
        n    = ($urandom_range(9) == 0) ? $urandom_range(20, TelegramCap - 1)
                                        : $urandom_range(1, 5);
        len  = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
        mode = answer_mode_e'($urandom_range(5));
        play_transaction(n, mode, len);
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                    $urandom_range(9) == 0);
      end
      // hold the input until every pending result is out
      if ($urandom_range(19) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_telegram_types();
    test_overflow();
    test_random_traffic(0, 0, TypeMasterSlave, 35);
    test_random_traffic(55, 0, TypeMasterMaster, 35);
    test_random_traffic(0, 55, TypeMasterSlave, 35);
    test_random_traffic(8, 8, TypeZero, 35);
    test_random_traffic(0, 0, TypeBroadcast, 20);
    drain_results();
    if (err_count == 0 && expected_bus_out.size() == 0) begin
      $display("[ebus_master_transaction_core] OK");
    end else begin
      $display("[ebus_master_transaction_core] ERROR");
    end
    $finish;
  end

endmodule
